// ===== rtl/core/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and helpers for the 3x3 median filter
// Sizes, register indexes, column cell type and small sort functions.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);        // column counter / address
    localparam int ROW_W      = $clog2(MAX_HEIGHT);       // output row counter
    localparam int FW_W       = 12;                       // frame_width register
    localparam int FH_W       = 13;                       // frame_height register
    localparam int CFG_W      = 13;                       // widest register
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 24;                       // three 8-bit channels
    localparam int LINE_W     = 2 * PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam logic [FW_W-1:0] FW_MIN   = 12'd3;
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MIN   = 13'd3;
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

    // One window column: per channel sorted low/mid/high, plus the raw middle pixel.
    typedef struct packed {
        logic [2:0][7:0] hi;
        logic [2:0][7:0] md;
        logic [2:0][7:0] lo;
        logic [PIX_W-1:0] ctr;
    } mf3_col_t;

    // Per-item control carried down the pipeline.
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } mf3_tag_t;

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mf3_line_ram.sv =====
// ----------------------------------------------------------------------------
// mf3_line_ram: two-row line store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_ram (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [mf3_pkg::COL_W-1:0]   wr_addr,
    input  wire logic [mf3_pkg::LINE_W-1:0]  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [mf3_pkg::COL_W-1:0]   rd_addr,
    output logic      [mf3_pkg::LINE_W-1:0]  rd_data
);
    import mf3_pkg::*;

    logic [LINE_W-1:0] mem_reg [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mf3_cell.sv =====
// ----------------------------------------------------------------------------
// mf3_cell: one window column cell
// Sorts the incoming column per channel and holds it; feeds the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              shift,
    input  wire mf3_pkg::mf3_col_t col_in,
    output mf3_pkg::mf3_col_t      col_out
);
    import mf3_pkg::*;

    mf3_col_t col_reg;
    mf3_col_t col_next;

    // sorting an already sorted column leaves it as is
    always_comb begin
        col_next.ctr = col_in.ctr;
        for (int c = 0; c < 3; c++) begin
            col_next.lo[c] = min3(col_in.lo[c], col_in.md[c], col_in.hi[c]);
            col_next.md[c] = med3(col_in.lo[c], col_in.md[c], col_in.hi[c]);
            col_next.hi[c] = max3(col_in.lo[c], col_in.md[c], col_in.hi[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift) begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median: two-stage median of three sorted columns
// Stage 1: max of lows, median of mids, min of highs. Stage 2: median of those.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire mf3_pkg::mf3_col_t          col_a,
    input  wire mf3_pkg::mf3_col_t          col_b,
    input  wire mf3_pkg::mf3_col_t          col_c,
    output logic [mf3_pkg::PIX_W-1:0]       median,
    output logic [mf3_pkg::PIX_W-1:0]       center
);
    import mf3_pkg::*;

    logic [2:0][7:0] lo_reg, md_reg, hi_reg;
    logic [PIX_W-1:0] ctr1_reg, ctr2_reg;
    logic [2:0][7:0] med_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                lo_reg[c]  <= max3(col_a.lo[c], col_b.lo[c], col_c.lo[c]);
                md_reg[c]  <= med3(col_a.md[c], col_b.md[c], col_c.md[c]);
                hi_reg[c]  <= min3(col_a.hi[c], col_b.hi[c], col_c.hi[c]);
                med_reg[c] <= med3(lo_reg[c], md_reg[c], hi_reg[c]);
            end
            ctr1_reg <= col_b.ctr;
            ctr2_reg <= ctr1_reg;
        end
    end

    assign median = med_reg;
    assign center = ctr2_reg;

endmodule

`default_nettype wire

// ===== rtl/core/median_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median filter
// Raster pixels in, median of the 3x3 neighborhood per channel out; frame
// border pixels pass through. Output lags one row plus one pixel.
// ----------------------------------------------------------------------------
//  channel | direction | transaction payload
//  s_      | in        | pixel_ch0..2, flush
//  m_      | out       | out_ch0..2, frame_last
//  cfg_    | in        | cfg_addr, cfg_wdata on cfg_we (no handshake)
//
// One pixel per clock sustained while the output is not stalled; from accept to
// m_valid a pixel passes the stage-1 register, the cell shift, the two median
// stages and the output register (the line RAM read is issued on the accepting edge).
// A stall on m_ready freezes the whole pipeline and drops s_ready.
// Synchronous active-low reset clears counters, cells and valid flags; the
// line RAM is not cleared, and no unwritten entry reaches an output.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3 (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mf3_pkg::CFG_W-1:0]    cfg_wdata,
    // pixel input
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_pixel_ch0,
    input  wire logic [7:0]                   s_pixel_ch1,
    input  wire logic [7:0]                   s_pixel_ch2,
    input  wire logic                         s_flush,
    // result output
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [7:0]                        m_out_ch0,
    output logic [7:0]                        m_out_ch1,
    output logic [7:0]                        m_out_ch2,
    output logic                              m_frame_last
);
    import mf3_pkg::*;

    // ---------------- configuration registers ----------------
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic            color_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
            color_mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                REG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // saturate sizes into their legal ranges
    logic [FW_W-1:0] width;
    logic [FH_W-1:0] height;

    always_comb begin
        width  = (frame_width_reg < FW_MIN) ? FW_MIN :
                 (frame_width_reg > FW_MAX) ? FW_MAX : frame_width_reg;
        height = (frame_height_reg < FH_MIN) ? FH_MIN :
                 (frame_height_reg > FH_MAX) ? FH_MAX : frame_height_reg;
    end

    // ---------------- pipeline advance ----------------
    logic m_valid_reg;
    logic en;
    logic accept;

    assign en      = !m_valid_reg || m_ready;   // output slot free or draining
    assign s_ready = en;
    assign accept  = s_valid && en;

    // ---------------- stage 0: position counters ----------------
    // in_row only matters as 0, 1 or "2 or more", so it saturates at 2.
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [1:0]       in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    mf3_tag_t         tag0;

    logic [FW_W:0] col_p1, col_p2;
    logic [FH_W:0] row_p1, row_p2;

    always_comb begin
        col_p1 = (FW_W+1)'(out_col_reg) + 1'b1;
        col_p2 = (FW_W+1)'(out_col_reg) + 2'd2;
        row_p1 = (FH_W+1)'(out_row_reg) + 1'b1;
        row_p2 = (FH_W+1)'(out_row_reg) + 2'd2;

        tag0.emit     = (in_row_reg == 2'd2) || (in_row_reg == 2'd1 && in_col_reg != '0);
        tag0.interior = (out_row_reg != '0) && (row_p2 <= (FH_W+1)'(height))
                     && (out_col_reg != '0) && (col_p2 <= (FW_W+1)'(width));
        tag0.last     = (col_p1 >= (FW_W+1)'(width)) && (row_p1 >= (FH_W+1)'(height));

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if ((FW_W+1)'(in_col_reg) + 1'b1 >= (FW_W+1)'(width)) begin
            in_col_next = '0;
            if (in_row_reg != 2'd2) begin
                in_row_next = in_row_reg + 1'b1;
            end
        end else begin
            in_col_next = in_col_reg + 1'b1;
        end

        if (tag0.emit) begin
            if (tag0.last) begin
                // frame done: everything restarts
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (col_p1 >= (FW_W+1)'(width)) begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // flush and grayscale force zeros into the stored samples
    logic [PIX_W-1:0] pix0;

    always_comb begin
        pix0 = s_flush ? '0 : {s_pixel_ch2, s_pixel_ch1, s_pixel_ch0};
        if (!color_mode_reg) begin
            pix0[PIX_W-1:8] = '0;
        end
    end

    // ---------------- stage 1: line RAM read data, cell shift ----------------
    logic             v1_reg;
    logic [PIX_W-1:0] pix1_reg;
    logic [COL_W-1:0] col1_reg;
    mf3_tag_t         tag1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg <= pix0;
            col1_reg <= in_col_reg;
            tag1_reg <= tag0;
        end
    end

    logic [LINE_W-1:0] line_rd;
    logic [PIX_W-1:0]  above, above2;
    logic              shift;

    assign above  = line_rd[PIX_W-1:0];
    assign above2 = line_rd[LINE_W-1:PIX_W];
    assign shift  = en && v1_reg;

    mf3_line_ram u_line_ram (
        .aclk    (aclk),
        .wr_en   (shift),
        .wr_addr (col1_reg),
        .wr_data ({above, pix1_reg}),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (line_rd)
    );

    // chain of column cells: newest column enters cell 0
    mf3_col_t col_new;
    mf3_col_t cell_q [3];

    always_comb begin
        col_new.lo  = pix1_reg;
        col_new.md  = above;
        col_new.hi  = above2;
        col_new.ctr = above;
    end

    mf3_cell u_cell0 (.aclk(aclk), .aresetn(aresetn), .shift(shift),
                      .col_in(col_new),   .col_out(cell_q[0]));
    mf3_cell u_cell1 (.aclk(aclk), .aresetn(aresetn), .shift(shift),
                      .col_in(cell_q[0]), .col_out(cell_q[1]));
    mf3_cell u_cell2 (.aclk(aclk), .aresetn(aresetn), .shift(shift),
                      .col_in(cell_q[1]), .col_out(cell_q[2]));

    // ---------------- stages 2 to 4: median, aligned with its tags ----------------
    logic     v2_reg, v3_reg, v4_reg;
    mf3_tag_t tag2_reg, tag3_reg, tag4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    logic [PIX_W-1:0] med;
    logic [PIX_W-1:0] ctr;

    mf3_median u_median (
        .aclk   (aclk),
        .en     (en),
        .col_a  (cell_q[0]),
        .col_b  (cell_q[1]),
        .col_c  (cell_q[2]),
        .median (med),
        .center (ctr)
    );

    // ---------------- output register ----------------
    logic [PIX_W-1:0] res;
    logic [PIX_W-1:0] out_reg;
    logic             last_reg;

    always_comb begin
        res = tag4_reg.interior ? med : ctr;
        if (!color_mode_reg) begin
            res[PIX_W-1:8] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v4_reg && tag4_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg  <= res;
            last_reg <= tag4_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_ch0    = out_reg[7:0];
    assign m_out_ch1    = out_reg[15:8];
    assign m_out_ch2    = out_reg[23:16];
    assign m_frame_last = last_reg;

    // ---------------- assertions ----------------
`ifndef SYNTHESIS
    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v4_reg))
        else $error("output valid without an item in the last stage");

    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        width >= FW_MIN && width <= FW_MAX)
        else $error("clamped width out of range");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(cell_q[1]) && $stable(in_col_reg)))
        else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_median_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// tb_median_filter_3x3: self-checking bench for the 3x3 median filter
// Streams frames of random size, mode and content through the block. A
// scoreboard mirrors the line buffers and the window, and predicts every
// output pixel. The prediction is compared field by field with what the
// block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_median_filter_3x3;

    import mf3_pkg::*;

    // Expected output pixel
    typedef struct {
        bit [7:0] ch0;
        bit [7:0] ch1;
        bit [7:0] ch2;
        bit       frame_last;
    } out_pixel_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow filter plus the queue of pixels still due out
    // ------------------------------------------------------------------------
    class median_scoreboard;
        bit [FW_W-1:0]    width_reg  = FW_RESET;
        bit [FH_W-1:0]    height_reg = FH_RESET;
        bit               color_reg  = 1'b0;
        bit [LINE_W-1:0]  line_mem [MAX_WIDTH];
        bit [PIX_W-1:0]   win [9];
        int               in_col, in_row, out_col, out_row;
        out_pixel_t       due_pixels [$];
        int               errors;
        int               results;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i]) win[i] = '0;
        endfunction

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
                REG_COLOR_MODE:   color_reg  = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_pixels.size();
        endfunction

        // rank 4 of 0..8 for one byte lane of the window
        function bit [7:0] lane_median(int lane);
            bit [7:0] v [9];
            bit [7:0] x;
            int j;
            for (int i = 0; i < 9; i++) begin
                x = win[i][8*lane +: 8];
                j = i;
                while (j > 0 && v[j-1] > x) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = x;
            end
            return v[4];
        endfunction

        // Advance the shadow filter by one accepted input transaction
        function void note_input(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2, bit fl);
            int w, h;
            bit [PIX_W-1:0] pix, above, above2;
            bit emit, interior, last;
            bit [7:0] v [3];
            out_pixel_t o;
            w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT
                                                                   : int'(height_reg);
            pix = fl ? '0 : {c2, c1, c0};
            if (!color_reg) pix[23:8] = '0;
            above  = line_mem[in_col][23:0];
            above2 = line_mem[in_col][47:24];
            for (int r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = above2;
            win[5] = above;
            win[8] = pix;
            line_mem[in_col] = {above, pix};

            // output lags one row plus one pixel
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row++;
            end else begin
                in_col++;
            end
            if (!emit) return;

            interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
            for (int c = 0; c < 3; c++) begin
                v[c] = interior ? lane_median(c) : win[4][8*c +: 8];
                if (!color_reg && c != 0) v[c] = '0;
            end
            last = (out_col + 1 >= w) && (out_row + 1 >= h);
            o.ch0 = v[0];
            o.ch1 = v[1];
            o.ch2 = v[2];
            o.frame_last = last;
            due_pixels.insert(due_pixels.size(), o);

            if (last) begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end else if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
        endtask

        // Compare one output transaction with the oldest prediction
        task check_result(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2, bit fl);
            out_pixel_t o;
            results++;
            if (due_pixels.size() == 0) begin
                report_mismatch("unexpected output pixel, ch0", c0, -1);
                return;
            end
            o = due_pixels.pop_front();
            if (c0 != o.ch0) report_mismatch("out_ch0", c0, o.ch0);
            if (c1 != o.ch1) report_mismatch("out_ch1", c1, o.ch1);
            if (c2 != o.ch2) report_mismatch("out_ch2", c2, o.ch2);
            if (fl != o.frame_last) report_mismatch("frame_last", fl, o.frame_last);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_pixel_ch0, s_pixel_ch1, s_pixel_ch2;
    logic                 s_flush;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_out_ch0, m_out_ch1, m_out_ch2;
    logic                 m_frame_last;

    median_filter_3x3 uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_ch0  (s_pixel_ch0),
        .s_pixel_ch1  (s_pixel_ch1),
        .s_pixel_ch2  (s_pixel_ch2),
        .s_flush      (s_flush),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_ch0    (m_out_ch0),
        .m_out_ch1    (m_out_ch1),
        .m_out_ch2    (m_out_ch2),
        .m_frame_last (m_frame_last)
    );

    median_scoreboard sb = new();

    int burst_left;      // transactions left in the current sender burst
    int hold_cycles;     // forced receiver stall, counted down by the receiver
    int items_sent;
    int frames_run;
    int color_frames;

    // 8-unit clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: far above the slowest legal run
    initial begin
        #(8 * 2000000);
        $display("timeout: %0d output pixels still due", sb.pending());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: picks a new stall pattern each time phase_cnt wraps; a nonzero
    // hold_cycles overrides it with a solid stall.
    // ------------------------------------------------------------------------
    initial begin
        int phase_cnt;
        int stall_style;
        m_ready     = 1'b0;
        hold_cycles = 0;
        phase_cnt   = 0;
        stall_style = 0;
        forever begin
            @(negedge aclk);
            if (phase_cnt == 0) stall_style = $urandom_range(0, 3);
            phase_cnt = (phase_cnt + 1) % 256;
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (stall_style)
                    0:       m_ready <= 1'b1;                          // no stalls
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 9) < 3);    // heavy stall
                    default: m_ready <= ((phase_cnt % 16) < 11);       // periodic
                endcase
            end
        end
    end

    // Output monitor: values sampled at the edge, before the DUT updates
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_ch0, m_out_ch1, m_out_ch2, m_frame_last);
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(data);
        sb.set_reg(idx, CFG_W'(data));
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One input transaction; bursts of random length with random gaps between
    task automatic push_item(bit [7:0] c0, bit [7:0] c1, bit [7:0] c2, bit fl);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pixel_ch0 <= c0;
        s_pixel_ch1 <= c1;
        s_pixel_ch2 <= c2;
        s_flush     <= fl;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(c0, c1, c2, fl);
        burst_left--;
        items_sent++;
    endtask

    // Wait until all results are in, then let anything still in the pipe drain
    task automatic wait_idle();
        while (sb.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // One frame: configure, W*H positions, then W+1 trailing items to drain.
    // style 0: random content with the odd mid-frame flush;
    // style 1: checkerboard of 0 and 255 in ch0, its inverse in ch1, 255 on every third item in ch2.
    task automatic run_frame(int w_reg, int h_reg, bit mode, int style);
        int w, h;
        bit [7:0] a, b, c;
        bit fl;
        cfg_write(REG_FRAME_WIDTH, w_reg);
        cfg_write(REG_FRAME_HEIGHT, h_reg);
        cfg_write(REG_COLOR_MODE, mode);
        w = (w_reg & 'hFFF) < 3 ? 3 : (w_reg & 'hFFF) > MAX_WIDTH ? MAX_WIDTH : (w_reg & 'hFFF);
        h = (h_reg & 'h1FFF) < 3 ? 3 : (h_reg & 'h1FFF) > MAX_HEIGHT ? MAX_HEIGHT
                                                                      : (h_reg & 'h1FFF);
        for (int n = 0; n < w * h + w + 1; n++) begin
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            c = 8'($urandom_range(0, 255));
            if (n < w * h) begin
                fl = (style == 0) && ($urandom_range(0, 19) == 0);
                if (style == 1) begin
                    a = ((n + n / w) % 2) ? 8'hFF : 8'h00;
                    b = ~a;
                    c = (n % 3 == 0) ? 8'hFF : 8'h00;
                end
            end else begin
                // trailing items: flush or plain pixels, both only feed the border
                fl = 1'($urandom_range(0, 1));
            end
            push_item(a, b, c, fl);
        end
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
        wait_idle();
        frames_run++;
        if (mode) color_frames++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_pixel_ch0 = '0;
        s_pixel_ch1 = '0;
        s_pixel_ch2 = '0;
        s_flush     = 1'b0;
        aresetn     = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        frames_run  = 0;
        color_frames = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: smallest frames, saturated sizes, extreme pixel values
        run_frame(3, 3, 1'b0, 1);
        run_frame(0, 0, 1'b1, 1);      // both sizes clamp up to 3

        // long receiver stall while the sender keeps offering
        hold_cycles = 400;
        run_frame(10, 6, 1'b1, 0);

        // random frames, mostly small
        while (items_sent < 1700) begin
            if ($urandom_range(0, 7) == 0)
                run_frame($urandom_range(13, 64), $urandom_range(3, 5),
                          1'($urandom_range(0, 1)), 0);
            else
                run_frame($urandom_range(1, 12), $urandom_range(2, 8),
                          1'($urandom_range(0, 1)), 0);
        end

        // oversized register values: only the register bits are kept (3 by 3)
        run_frame(4099, 8195, 1'b1, 0);
        run_frame(5, 4, 1'b1, 0);

        wait_idle();
        $display("covered %0d frames (%0d color), %0d input transactions, %0d pixels out",
                 frames_run, color_frames, items_sent, sb.results);
        $display("small and clamped sizes, truncated size writes, flushes mid-frame");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
